// File: sv/spag_pkg.sv
// shared constants, codes and control types for the spectrum periodize address generator
// no dependencies; every other file of the block uses it by scoped names
package spag_pkg;

	localparam int CFG_W     = 11;
	localparam int ZOOM_W    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int COORD_W   = 10;
	localparam int DEST_W    = 26;
	localparam int SEL_W     = 2;

	localparam int NSLOT  = 8;
	localparam int SLOT_W = 3;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZOOM = 2'd2;

	localparam logic [CFG_W-1:0]  ROWS_RST = 11'd1024;
	localparam logic [CFG_W-1:0]  COLS_RST = 11'd1024;
	localparam logic [ZOOM_W-1:0] ZOOM_RST = 4'd2;

	localparam logic [SEL_W-1:0] SEL_SELF     = 2'd0;
	localparam logic [SEL_W-1:0] SEL_RIGHT    = 2'd1;
	localparam logic [SEL_W-1:0] SEL_NEXT_ROW = 2'd2;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_COPY = 2'd0;
	localparam mode_t MODE_Z2   = 2'd1;
	localparam mode_t MODE_ZN   = 2'd2;

	typedef struct packed {
		logic [SLOT_W-1:0]            last_slot;
		logic [NSLOT-1:0][SEL_W-1:0] sel;
	} spag_ctl_t;

endpackage

// File: sv/spag_if.sv
// valid/ready channel interfaces: source coordinates, destination writes, configuration
// depends on spag_pkg
interface spag_coord_if;
	logic                        valid;
	logic                        ready;
	logic [spag_pkg::COORD_W-1:0] src_row;
	logic [spag_pkg::COORD_W-1:0] src_col;
	modport source (output valid, src_row, src_col, input ready);
	modport sink (input valid, src_row, src_col, output ready);
endinterface

interface spag_addr_if;
	logic                       valid;
	logic                       ready;
	logic [spag_pkg::DEST_W-1:0] dest_index;
	logic [spag_pkg::SEL_W-1:0]  source_select;
	logic                       last_write;
	modport source (output valid, dest_index, source_select, last_write, input ready);
	modport sink (input valid, dest_index, source_select, last_write, output ready);
endinterface

interface spag_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [spag_pkg::CFG_IDX_W-1:0] index;
	logic [spag_pkg::CFG_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/spag_front.sv
// front end: configuration registers, range check and a three stage index pipeline
// that turns one source coordinate into a packed list of destination writes
// depends on spag_pkg and spag_if
module spag_front #(
	parameter int MAX_ROWS = 1024,
	parameter int MAX_COLS = 1024,
	parameter int MAX_ZOOM = 8,
	parameter int IW       = 26
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	spag_cfg_if.sink                               cfg,
	spag_coord_if.sink                             coord,
	input  logic                                   full,
	output logic                                   push,
	output logic [spag_pkg::NSLOT-1:0][IW-1:0]     push_idx,
	output spag_pkg::spag_ctl_t                    push_ctl
);

	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int CLW = $clog2(MAX_COLS + 1);
	localparam int ZW  = $clog2(MAX_ZOOM + 1);
	localparam int FCW = $clog2(MAX_COLS / 2 + 2);
	localparam int ZCW = $clog2(MAX_COLS * MAX_ZOOM / 2 + 2);
	localparam int ZRW = $clog2(MAX_ROWS * MAX_ZOOM + 1);
	localparam int CZW = CLW + ZW;
	localparam int KW  = FCW + 1;

	// configuration registers
	logic [spag_pkg::CFG_W-1:0]  rows_q;
	logic [spag_pkg::CFG_W-1:0]  cols_q;
	logic [spag_pkg::ZOOM_W-1:0] zoom_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= spag_pkg::ROWS_RST;
			cols_q <= spag_pkg::COLS_RST;
			zoom_q <= spag_pkg::ZOOM_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				spag_pkg::REG_ROWS: rows_q <= cfg.data;
				spag_pkg::REG_COLS: cols_q <= cfg.data;
				spag_pkg::REG_ZOOM: zoom_q <= cfg.data[spag_pkg::ZOOM_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables, back to front
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	assign en3 = !v_s3 || !full;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign coord.ready = en1;
	assign push = v_s3 && !full;

	// geometry from the registers, saturated into range
	logic [RW-1:0]        rows_c;
	logic [CLW-1:0]       cols_c;
	logic [ZW-1:0]        z_c;
	logic [FCW-1:0]       fc_c;
	logic [CZW-1:0]       cz_c;
	logic [ZCW-1:0]       zc_c;
	logic [ZRW-1:0]       rz1_c;
	spag_pkg::mode_t      mode_c;
	logic                 range_ok_c;
	logic                 lrow_c;
	logic                 lcol_c;

	always_comb begin
		rows_c = (rows_q == '0) ? RW'(1) :
			((rows_q > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_q));
		cols_c = (cols_q == '0) ? CLW'(1) :
			((cols_q > MAX_COLS) ? CLW'(MAX_COLS) : CLW'(cols_q));
		z_c    = (zoom_q > MAX_ZOOM) ? ZW'(MAX_ZOOM) : ZW'(zoom_q);
		fc_c   = FCW'(cols_c >> 1) + FCW'(1);
		cz_c   = CZW'(cols_c) * CZW'(z_c);
		if (z_c <= ZW'(1)) begin
			mode_c = spag_pkg::MODE_COPY;
		end else if (z_c == ZW'(2)) begin
			mode_c = spag_pkg::MODE_Z2;
		end else begin
			mode_c = spag_pkg::MODE_ZN;
		end
		// plain copy uses the source width as row pitch
		zc_c  = (mode_c == spag_pkg::MODE_COPY) ? ZCW'(fc_c) : (ZCW'(cz_c >> 1) + ZCW'(1));
		rz1_c = ZRW'(rows_c) * ZRW'(z_c - ZW'(1));
		range_ok_c = (coord.src_row < rows_c) && (coord.src_col < fc_c);
		lrow_c = (32'(coord.src_row) == 32'(rows_c) - 32'd1);
		lcol_c = (32'(coord.src_col) == 32'(fc_c) - 32'd1);
	end

	// stage 1
	logic [spag_pkg::COORD_W-1:0] r_s1, c_s1;
	logic [RW-1:0]                rows_s1;
	logic [FCW-1:0]               fc_s1;
	logic [ZCW-1:0]               zc_s1;
	logic [ZRW-1:0]               rz1_s1;
	spag_pkg::mode_t              mode_s1;
	logic                         lrow_s1, lcol_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			// out-of-range coordinates are dropped here
			v_s1 <= coord.valid && range_ok_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			r_s1    <= coord.src_row;
			c_s1    <= coord.src_col;
			rows_s1 <= rows_c;
			fc_s1   <= fc_c;
			zc_s1   <= zc_c;
			rz1_s1  <= rz1_c;
			mode_s1 <= mode_c;
			lrow_s1 <= lrow_c;
			lcol_s1 <= lcol_c;
		end
	end

	// stage 2: row base products
	logic [IW-1:0]   p_top_s2, p_bot_s2, p_bt_s2, p_tb_s2, p_tbr_s2, p_lim_s2;
	logic [IW-1:0]   c_s2;
	logic [KW-1:0]   koff_s2, doff_s2;
	spag_pkg::mode_t mode_s2;
	logic            lrow_s2, lcol_s2;

	logic [IW-1:0] zc_w, r_w, rows_w;
	logic [KW-1:0] koff_c, doff_c;

	always_comb begin
		zc_w   = IW'(zc_s1);
		r_w    = IW'(r_s1);
		rows_w = IW'(rows_s1);
		koff_c = (KW'(fc_s1) << 1) - KW'(c_s1) - KW'(2);
		doff_c = ((KW'(fc_s1) - KW'(c_s1)) << 1) - KW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			p_top_s2 <= r_w * zc_w;
			p_bot_s2 <= (IW'(rz1_s1) + r_w) * zc_w;
			p_bt_s2  <= (IW'(rz1_s1) - r_w - IW'(1)) * zc_w;
			p_tb_s2  <= (rows_w - r_w - IW'(1)) * zc_w;
			p_tbr_s2 <= (((rows_w - r_w) << 1) - IW'(1)) * zc_w;
			p_lim_s2 <= ((rows_w << 1) - IW'(1)) * zc_w;
			c_s2     <= IW'(c_s1);
			koff_s2  <= koff_c;
			doff_s2  <= doff_c;
			mode_s2  <= mode_s1;
			lrow_s2  <= lrow_s1;
			lcol_s2  <= lcol_s1;
		end
	end

	// stage 3: the eight candidate indices
	logic [IW-1:0]   tl_s3, bl_s3, tr_s3, br_s3, tbl_s3, tbr_s3, btl_s3, btr_s3, lim_s3;
	spag_pkg::mode_t mode_s3;
	logic            lrow_s3, lcol_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			tl_s3   <= p_top_s2 + c_s2;
			bl_s3   <= p_bot_s2 + c_s2;
			tr_s3   <= p_top_s2 + IW'(koff_s2);
			br_s3   <= p_bot_s2 + IW'(koff_s2);
			tbl_s3  <= p_top_s2 + c_s2 + (p_tb_s2 << 1);
			tbr_s3  <= p_top_s2 + IW'(koff_s2) + p_tbr_s2 + IW'(1);
			btl_s3  <= p_bt_s2 + c_s2;
			btr_s3  <= p_bt_s2 + c_s2 + IW'(doff_s2);
			lim_s3  <= p_lim_s2;
			mode_s3 <= mode_s2;
			lrow_s3 <= lrow_s2;
			lcol_s3 <= lcol_s2;
		end
	end

	// pack the writes in emission order
	logic [spag_pkg::SEL_W-1:0] selr, seln;
	logic                       tbr_ok;

	always_comb begin
		selr   = lcol_s3 ? spag_pkg::SEL_SELF : spag_pkg::SEL_RIGHT;
		seln   = lrow_s3 ? spag_pkg::SEL_SELF : spag_pkg::SEL_NEXT_ROW;
		tbr_ok = tbr_s3 < lim_s3;
		push_idx = '0;
		push_ctl.sel = '0;
		push_ctl.last_slot = '0;
		push_idx[0] = tl_s3;
		unique case (mode_s3)
			spag_pkg::MODE_COPY: begin
				push_ctl.last_slot = spag_pkg::SLOT_W'(0);
			end
			spag_pkg::MODE_Z2: begin
				push_idx[1] = bl_s3;
				push_idx[2] = tr_s3;
				push_idx[3] = br_s3;
				push_ctl.sel[2] = selr;
				push_ctl.sel[3] = selr;
				push_ctl.last_slot = spag_pkg::SLOT_W'(3);
			end
			spag_pkg::MODE_ZN: begin
				push_idx[1] = bl_s3;
				push_idx[2] = tbl_s3;
				push_ctl.sel[2] = seln;
				if (tbr_ok) begin
					push_idx[3] = tbr_s3;
					push_idx[4] = btr_s3;
					push_idx[5] = btl_s3;
					push_idx[6] = tr_s3;
					push_idx[7] = br_s3;
					push_ctl.sel[6] = selr;
					push_ctl.sel[7] = selr;
					push_ctl.last_slot = spag_pkg::SLOT_W'(7);
				end else begin
					push_idx[3] = btr_s3;
					push_idx[4] = btl_s3;
					push_idx[5] = tr_s3;
					push_idx[6] = br_s3;
					push_ctl.sel[5] = selr;
					push_ctl.sel[6] = selr;
					push_ctl.last_slot = spag_pkg::SLOT_W'(6);
				end
			end
			default: begin
				push_ctl.last_slot = spag_pkg::SLOT_W'(0);
			end
		endcase
	end

endmodule

// File: sv/spag_queue.sv
// short queue of packed write lists between the front pipeline and the write sequencer
// depends on spag_pkg
module spag_queue #(
	parameter int IW = 26
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic [spag_pkg::NSLOT-1:0][IW-1:0]  push_idx,
	input  spag_pkg::spag_ctl_t                 push_ctl,
	input  logic                                pop,
	output logic                                full,
	output logic                                empty,
	output logic [spag_pkg::NSLOT-1:0][IW-1:0]  head_idx,
	output spag_pkg::spag_ctl_t                 head_ctl
);

	logic [spag_pkg::NSLOT-1:0][IW-1:0] idx_q [spag_pkg::QDEPTH];
	spag_pkg::spag_ctl_t                ctl_q [spag_pkg::QDEPTH];
	logic [spag_pkg::QPTR_W-1:0]        wr_q, rd_q;
	logic [spag_pkg::QPTR_W:0]          cnt_q;

	assign full  = (cnt_q == (spag_pkg::QPTR_W+1)'(spag_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign head_idx = idx_q[rd_q];
	assign head_ctl = ctl_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + spag_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + spag_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (spag_pkg::QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (spag_pkg::QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			idx_q[wr_q] <= push_idx;
			ctl_q[wr_q] <= push_ctl;
		end
	end

endmodule

// File: sv/spag_back.sv
// write sequencer: steps through the head list of the queue, one destination write per cycle while addr.ready is high
// depends on spag_pkg and spag_if
module spag_back #(
	parameter int IW = 26
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                empty,
	input  logic [spag_pkg::NSLOT-1:0][IW-1:0]  head_idx,
	input  spag_pkg::spag_ctl_t                 head_ctl,
	output logic                                pop,
	spag_addr_if.source                         addr
);

	logic [spag_pkg::SLOT_W-1:0] slot_q;
	logic [IW-1:0]               cur_idx;
	logic                        fire;

	assign cur_idx            = head_idx[slot_q];
	assign addr.valid         = !empty;
	assign addr.dest_index    = cur_idx[spag_pkg::DEST_W-1:0];
	assign addr.source_select = head_ctl.sel[slot_q];
	assign addr.last_write    = (slot_q == head_ctl.last_slot);
	assign fire               = addr.valid && addr.ready;
	assign pop                = fire && addr.last_write;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (fire) begin
			slot_q <= pop ? '0 : slot_q + spag_pkg::SLOT_W'(1);
		end
	end

endmodule

// File: sv/spectrum_periodize_address_gen.sv
// Scatter address generator for spreading a real 2-D FFT half spectrum into the half spectrum
// of a zoomed image. Each accepted (src_row, src_col) yields 1 write at zoom 1 or below, 4 at
// zoom 2, and 7 or 8 at larger zooms (the top-bottom right write is dropped past the bound),
// the last one flagged with last_write. Items outside the spectrum yield nothing. Writes leave
// one per cycle while addr.ready is high, so the single write port of the sequencer sets the
// sustained rate. The front pipeline is registered, and a 4-entry queue lets it run ahead of
// the sequencer, so a new coordinate is taken while earlier writes are still going out.
// depends on spag_pkg, spag_if, spag_front, spag_queue and spag_back
module spectrum_periodize_address_gen #(
	parameter int MAX_ROWS = 1024,
	parameter int MAX_COLS = 1024,
	parameter int MAX_ZOOM = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	spag_cfg_if.sink    cfg,
	spag_coord_if.sink  coord,
	spag_addr_if.source addr
);

	localparam int IW_RAW = $clog2(MAX_ROWS * MAX_ZOOM + 1) + $clog2(MAX_COLS * MAX_ZOOM / 2 + 2);
	localparam int IW     = (IW_RAW > spag_pkg::DEST_W) ? IW_RAW : spag_pkg::DEST_W;

	logic                               push, pop, full, empty;
	logic [spag_pkg::NSLOT-1:0][IW-1:0] push_idx, head_idx;
	spag_pkg::spag_ctl_t                push_ctl, head_ctl;

	spag_front #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.MAX_ZOOM (MAX_ZOOM),
		.IW       (IW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.coord    (coord),
		.full     (full),
		.push     (push),
		.push_idx (push_idx),
		.push_ctl (push_ctl)
	);

	spag_queue #(
		.IW (IW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_idx (push_idx),
		.push_ctl (push_ctl),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.head_idx (head_idx),
		.head_ctl (head_ctl)
	);

	spag_back #(
		.IW (IW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head_idx (head_idx),
		.head_ctl (head_ctl),
		.pop      (pop),
		.addr     (addr)
	);

endmodule

// File: sv/spag_checker.sv
// port-level checks on the address generator, attached to the top level by bind
// depends on spag_pkg, spag_if and spectrum_periodize_address_gen
module spag_checker (
	input  logic        clk,
	input  logic        arst_n,
	spag_coord_if.sink  coord,
	spag_addr_if.source addr
);

	logic [7:0]                  pend_q;
	logic [spag_pkg::SLOT_W-1:0] run_q;
	logic                        in_fire, out_fire, done;

	assign in_fire  = coord.valid && coord.ready;
	assign out_fire = addr.valid && addr.ready;
	assign done     = out_fire && addr.last_write;

	// items taken but not yet finished, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			run_q  <= '0;
		end else begin
			if (in_fire && !done && pend_q != 8'hff) begin
				pend_q <= pend_q + 8'd1;
			end else if (done && !in_fire && pend_q != 8'hff) begin
				pend_q <= pend_q - 8'd1;
			end
			if (out_fire) begin
				run_q <= addr.last_write ? '0 : run_q + spag_pkg::SLOT_W'(1);
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		addr.valid && !addr.ready |=> addr.valid && $stable(addr.dest_index) &&
			$stable(addr.source_select) && $stable(addr.last_write))
		else $error("write changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> pend_q != 8'd0)
		else $error("final write without a pending item");

	a_max_writes: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && run_q == spag_pkg::SLOT_W'(spag_pkg::NSLOT - 1) |-> addr.last_write)
		else $error("more than eight writes for one item");

endmodule

bind spectrum_periodize_address_gen spag_checker u_spag_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.coord  (coord),
	.addr   (addr)
);

// File: sim/tb.sv
// self-checking bench for spectrum_periodize_address_gen: random valid/ready traffic on the
// coordinate and write channels, register writes between phases, writes checked in order
// depends on spag_pkg, spag_if and the block's rtl
`timescale 1ns / 1ps

module tb;

	localparam logic [spag_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 5;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_GUARD  = 50000;
	localparam int PHASE_ITEMS  = 38;
	localparam int NUM_PHASES   = 11;
	localparam int MAX_SHOWN    = 10;

	typedef struct packed {
		logic [spag_pkg::COORD_W-1:0] row;
		logic [spag_pkg::COORD_W-1:0] col;
	} coord_t;

	typedef struct packed {
		logic [spag_pkg::DEST_W-1:0] idx;
		logic [spag_pkg::SEL_W-1:0]  sel;
		logic                        last;
	} dest_wr_t;

	logic clk;
	logic arst_n;

	spag_cfg_if   cfg_ch ();
	spag_coord_if coord_ch ();
	spag_addr_if  addr_ch ();

	spectrum_periodize_address_gen uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.coord  (coord_ch),
		.addr   (addr_ch)
	);

	// shadow registers
	logic [spag_pkg::CFG_W-1:0]  img_rows;
	logic [spag_pkg::CFG_W-1:0]  img_cols;
	logic [spag_pkg::ZOOM_W-1:0] zoom;

	coord_t   pending_coords[$];
	dest_wr_t expected_writes[$];
	int       pushed_items = 0;
	int       accepted_items = 0;
	int       mismatches = 0;
	int       send_gap;
	int       recv_gap;
	bit       no_idle;
	bit       hold_go;
	logic     long_hold;
	coord_t   next_coord;

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (no_idle || k < 55)
			return 0;
		if (k < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// expected destination writes for one accepted coordinate
	function automatic void predict_writes(logic [spag_pkg::COORD_W-1:0] row_in,
			logic [spag_pkg::COORD_W-1:0] col_in);
		longint rows, cols, z, fc, zr, zc, r, c, bottom, tl, bl, tr, br, tbl, tbr, btl, btr;
		logic [spag_pkg::SEL_W-1:0] sel_right;
		dest_wr_t wr[$];
		r = row_in;
		c = col_in;
		rows = img_rows;
		cols = img_cols;
		z = zoom;
		if (rows < 1) rows = 1;
		if (rows > 1024) rows = 1024;
		if (cols < 1) cols = 1;
		if (cols > 1024) cols = 1024;
		if (z > 8) z = 8;
		fc = cols / 2 + 1;
		if (r >= rows || c >= fc)
			return;
		if (z <= 1) begin
			expected_writes.push_back('{spag_pkg::DEST_W'(r * fc + c), spag_pkg::SEL_SELF, 1'b1});
			return;
		end
		zr = rows * z;
		zc = (cols * z) / 2 + 1;
		bottom = (zr - rows + r) * zc;
		tl = r * zc + c;
		bl = bottom + c;
		tr = r * zc + 2 * fc - c - 2;
		br = bottom + 2 * fc - c - 2;
		sel_right = (c == fc - 1) ? spag_pkg::SEL_SELF : spag_pkg::SEL_RIGHT;
		wr.push_back('{spag_pkg::DEST_W'(tl), spag_pkg::SEL_SELF, 1'b0});
		wr.push_back('{spag_pkg::DEST_W'(bl), spag_pkg::SEL_SELF, 1'b0});
		if (z != 2) begin
			tbl = tl + 2 * (rows - r - 1) * zc;
			tbr = tr + (2 * (rows - r) - 1) * zc + 1;
			btl = (zr - rows - 1 - r) * zc + c;
			btr = btl + 2 * (fc - c) - 1;
			wr.push_back('{spag_pkg::DEST_W'(tbl),
				(r == rows - 1) ? spag_pkg::SEL_SELF : spag_pkg::SEL_NEXT_ROW, 1'b0});
			// top-bottom right write only inside the mirrored bound
			if (tbr < zc * (2 * rows - 1))
				wr.push_back('{spag_pkg::DEST_W'(tbr), spag_pkg::SEL_SELF, 1'b0});
			wr.push_back('{spag_pkg::DEST_W'(btr), spag_pkg::SEL_SELF, 1'b0});
			wr.push_back('{spag_pkg::DEST_W'(btl), spag_pkg::SEL_SELF, 1'b0});
		end
		wr.push_back('{spag_pkg::DEST_W'(tr), sel_right, 1'b0});
		wr.push_back('{spag_pkg::DEST_W'(br), sel_right, 1'b0});
		wr[wr.size() - 1].last = 1'b1;
		foreach (wr[i])
			expected_writes.push_back(wr[i]);
	endfunction

	function automatic void report_mismatch(string what, dest_wr_t want, dest_wr_t got);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("tb: %s expected idx=%0d sel=%0d last=%0d got idx=%0d sel=%0d last=%0d",
				what, want.idx, want.sel, want.last, got.idx, got.sel, got.last);
	endfunction

	// coordinate driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_ch.valid <= 1'b0;
			coord_ch.src_row <= '0;
			coord_ch.src_col <= '0;
			send_gap <= 0;
		end else begin
			if (coord_ch.valid && coord_ch.ready) begin
				predict_writes(coord_ch.src_row, coord_ch.src_col);
				accepted_items++;
			end
			if (!coord_ch.valid || coord_ch.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					coord_ch.valid <= 1'b0;
				end else if (pending_coords.size() > 0) begin
					next_coord = pending_coords.pop_front();
					coord_ch.valid <= 1'b1;
					coord_ch.src_row <= next_coord.row;
					coord_ch.src_col <= next_coord.col;
					send_gap <= pick_gap();
				end else begin
					coord_ch.valid <= 1'b0;
				end
			end
		end
	end

	// write monitor and receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_ch.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (addr_ch.valid && addr_ch.ready) begin
				if (expected_writes.size() == 0)
					report_mismatch("unexpected write", '0,
						'{addr_ch.dest_index, addr_ch.source_select, addr_ch.last_write});
				else if (expected_writes[0] !==
						{addr_ch.dest_index, addr_ch.source_select, addr_ch.last_write})
					report_mismatch("write mismatch", expected_writes.pop_front(),
						'{addr_ch.dest_index, addr_ch.source_select, addr_ch.last_write});
				else
					void'(expected_writes.pop_front());
			end
			if (long_hold) begin
				addr_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				addr_ch.ready <= 1'b0;
			end else begin
				addr_ch.ready <= 1'b1;
				if (addr_ch.valid && addr_ch.ready)
					recv_gap <= pick_gap();
			end
		end
	end

	// long receiver hold-off so the block fills and stalls its input
	initial begin : hold_off
		long_hold = 1'b0;
		wait (hold_go);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin : watchdog
		#(2 * HALF_PERIOD * 800000);
		$display("tb: FAIL");
		$finish;
	end

	task automatic push_coord(int row, int col);
		pending_coords.push_back('{spag_pkg::COORD_W'(row), spag_pkg::COORD_W'(col)});
		pushed_items++;
	endtask

	task automatic wait_idle();
		int n;
		n = 0;
		while ((accepted_items != pushed_items || expected_writes.size() != 0) &&
				n < DRAIN_GUARD) begin
			@(posedge clk);
			n++;
		end
		// ignored items may still sit in the front pipeline
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [spag_pkg::CFG_IDX_W-1:0] idx,
			logic [spag_pkg::CFG_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			spag_pkg::REG_ROWS: img_rows = data;
			spag_pkg::REG_COLS: img_cols = data;
			spag_pkg::REG_ZOOM: zoom = data[spag_pkg::ZOOM_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(int rows, int cols, int zdata);
		wait_idle();
		cfg_write(spag_pkg::REG_ROWS, spag_pkg::CFG_W'(rows));
		cfg_write(spag_pkg::REG_COLS, spag_pkg::CFG_W'(cols));
		cfg_write(spag_pkg::REG_ZOOM, spag_pkg::CFG_W'(zdata));
	endtask

	// mostly raster runs inside the spectrum, some noise over the whole field range
	task automatic random_items(int n);
		int rows, fc, rr, cc;
		rows = (img_rows < 1) ? 1 : (img_rows > 1024) ? 1024 : int'(img_rows);
		fc = ((img_cols < 1) ? 1 : (img_cols > 1024) ? 1024 : int'(img_cols)) / 2 + 1;
		rr = $urandom_range(0, rows - 1);
		cc = $urandom_range(0, fc - 1);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				push_coord($urandom_range(0, 1023), $urandom_range(0, 1023));
			end else begin
				if ($urandom_range(0, 7) == 0) begin
					rr = $urandom_range(0, rows - 1);
					cc = $urandom_range(0, fc - 1);
				end
				push_coord(rr, cc);
				cc++;
				if (cc >= fc) begin
					cc = 0;
					rr = (rr + 1) % rows;
				end
			end
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		img_rows = spag_pkg::ROWS_RST;
		img_cols = spag_pkg::COLS_RST;
		zoom = spag_pkg::ZOOM_RST;
		no_idle = 1'b0;
		hold_go = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset settings: corners of the spectrum and items outside it
		push_coord(0, 0);
		push_coord(1023, 512);
		push_coord(0, 512);
		push_coord(1023, 0);
		push_coord(512, 256);
		push_coord(1023, 1023);
		push_coord(0, 513);

		// tiny spectrum at zoom 3: last row, last column and the bound check
		set_config(3, 4, 3);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				push_coord(r, c);
		push_coord(3, 0);

		// oversized registers saturate
		set_config(2047, 2047, 2047);
		push_coord(1023, 512);
		push_coord(0, 0);

		// zero registers: single element, identity copy
		set_config(0, 0, 0);
		push_coord(0, 0);
		push_coord(0, 1);
		push_coord(1, 0);
		wait_idle();
		cfg_write(REG_NONE, spag_pkg::CFG_W'($urandom_range(0, 2047)));

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == 0)
				set_config(1024, 1024, 8);
			else if (p == 2)
				set_config(1 + $urandom_range(0, 3), 1 + $urandom_range(0, 7), 2);
			else if (p == 3)
				set_config(1 + $urandom_range(0, 7), 1 + $urandom_range(0, 15), 1);
			else if ($urandom_range(0, 3) == 0)
				set_config($urandom_range(0, 2047), $urandom_range(0, 2047),
					$urandom_range(0, 2047));
			else
				set_config($urandom_range(1, 12), $urandom_range(1, 24), $urandom_range(0, 15));
			no_idle = (p == 2);
			if (p == 1)
				hold_go = 1'b1;
			random_items(PHASE_ITEMS);
		end

		wait_idle();
		no_idle = 1'b0;
		if (accepted_items != pushed_items)
			mismatches++;
		foreach (expected_writes[i])
			report_mismatch("missing write", expected_writes[i], '0);
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
